@@ design/char_bigram_histogram_assert.svh @@
// Assertion macros for the character bigram histogram block.
// Included by the top level; depends on nothing else.
`ifndef CHAR_BIGRAM_HISTOGRAM_ASSERT_SVH
`define CHAR_BIGRAM_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CBH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CBH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cbh_pkg.sv @@
// Shared constants and helper functions for the character bigram histogram.
// No dependencies.
package cbh_pkg;

    localparam int CLASS_W     = 5;
    localparam int ADDR_W      = 10;
    localparam int NUM_CLASSES = 28;
    localparam int PAIR_DEPTH  = NUM_CLASSES * NUM_CLASSES;

    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [ADDR_W-1:0]  t_addr;

    localparam t_class CLASS_SPACE   = 5'd26;
    localparam t_class CLASS_NEWLINE = 5'd27;
    localparam t_class CLASS_NONE    = 5'd31;
    localparam t_class CLASS_LAST    = 5'd27;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam t_addr ADDR_LAST = t_addr'(PAIR_DEPTH - 1);

    // Fold to upper case and map to a class code
    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        c = CLASS_NONE;
        if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
            c = t_class'(b - CHAR_LOWER_A);
        end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            c = t_class'(b - CHAR_UPPER_A);
        end else if (b == CHAR_SPACE) begin
            c = CLASS_SPACE;
        end else if (b == CHAR_NEWLINE) begin
            c = CLASS_NEWLINE;
        end
        return c;
    endfunction

    // Row-major entry index lead*28 + trail, done as shifts, a subtract and an add
    function automatic t_addr pair_addr(input t_class lead, input t_class trail);
        t_addr a32;
        t_addr a4;
        a32 = {lead, 5'b0};
        a4  = {3'b0, lead, 2'b0};
        return a32 - a4 + t_addr'(trail);
    endfunction

endpackage

@@ design/cbh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 784
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; a read of the entry being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/char_bigram_histogram.sv @@
// Character bigram histogram: top level with the counter read-modify-write pipe.
// Depends on cbh_pkg, cbh_ram and char_bigram_histogram_assert.svh.
//
//  channel   valid        stall        payload
//  request   i_in_valid   o_in_stall   i_cmd, i_byte_value, i_first_class, i_second_class
//  result    o_out_valid  i_out_stall  o_pair_count
//
// One request per cycle sustained. The counter RAM read is issued as a request
// is taken; the next cycle adds one and writes back, with a one-entry forward
// covering a back-to-back hit. Read counts pass the RAM and result registers.
// After reset a clearing pass writes zero to all 784 counters, one a cycle,
// with o_in_stall high. A held result stalls the pipe only on a read request.
module char_bigram_histogram #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_byte_value,
    input  logic [4:0]  i_first_class,
    input  logic [4:0]  i_second_class,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pair_count
);
    import cbh_pkg::*;

    `include "char_bigram_histogram_assert.svh"

    localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Clearing pass
    logic  r_clr_busy, n_clr_busy;
    t_addr r_clr_addr, n_clr_addr;

    // Previous character class
    t_class r_prev, n_prev;

    // Modify stage
    logic  r_s_valid, n_s_valid;
    logic  r_s_cmd;
    logic  r_s_live;   // text: pair counts; read: classes in range
    t_addr r_s_addr;

    // Forward of the last write
    logic                   r_fwd_valid;
    t_addr                  r_fwd_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    // Result register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_pair_count;

    logic                   w_accept, w_retire, w_op_we, w_ram_we;
    t_class                 w_cls;
    logic                   w_live;
    t_addr                  w_raddr, w_waddr;
    logic [COUNT_WIDTH-1:0] w_rdata, w_cur, w_new, w_wdata;
    logic [EXT_W-1:0]       w_ext;
    logic [31:0]            w_sat;

    // Handshake
    assign w_retire   = r_s_valid && (!r_s_cmd || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s_valid && !w_retire);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Request decode and counter address
    always_comb begin
        w_cls = classify(i_byte_value);
        if (i_cmd) begin
            w_live  = (i_first_class <= CLASS_LAST) && (i_second_class <= CLASS_LAST);
            w_raddr = pair_addr(i_first_class, i_second_class);
        end else begin
            w_live  = (w_cls <= CLASS_LAST) && (r_prev <= CLASS_LAST);
            w_raddr = pair_addr(r_prev, w_cls);
        end
    end

    // Predecessor update on text requests
    always_comb begin
        n_prev = r_prev;
        if (w_accept && !i_cmd) begin
            n_prev = (w_cls == CLASS_NEWLINE) ? CLASS_NONE : w_cls;
        end
    end

    // Modify: forward, saturating increment
    assign w_cur   = (r_fwd_valid && (r_fwd_addr == r_s_addr)) ? r_fwd_data : w_rdata;
    assign w_new   = w_cur + COUNT_WIDTH'(1);
    assign w_op_we = w_retire && !r_s_cmd && r_s_live && (w_cur != COUNT_MAX);

    // Read result clipped to 32 bits
    assign w_ext = EXT_W'(w_cur);
    assign w_sat = (w_ext > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_ext[31:0];

    // RAM write port: clearing pass or counter update
    assign w_ram_we = r_clr_busy || w_op_we;
    assign w_waddr  = r_clr_busy ? r_clr_addr : r_s_addr;
    assign w_wdata  = r_clr_busy ? '0 : w_new;

    // Clearing pass sequencing
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + t_addr'(1);
            if (r_clr_addr == ADDR_LAST) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    // Stage and result occupancy
    always_comb begin
        n_s_valid = r_s_valid;
        if (w_accept) begin
            n_s_valid = 1'b1;
        end else if (w_retire) begin
            n_s_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_retire && r_s_cmd) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    cbh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (PAIR_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_prev      <= CLASS_NONE;
            r_s_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_busy  <= n_clr_busy;
            r_clr_addr  <= n_clr_addr;
            r_prev      <= n_prev;
            r_s_valid   <= n_s_valid;
            r_out_valid <= n_out_valid;
            if (w_retire) begin
                r_fwd_valid <= w_op_we;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s_cmd  <= i_cmd;
            r_s_live <= w_live;
            r_s_addr <= w_raddr;
        end
        if (w_retire) begin
            r_fwd_addr <= r_s_addr;
            r_fwd_data <= w_new;
        end
        if (w_retire && r_s_cmd) begin
            r_pair_count <= r_s_live ? w_sat : 32'd0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pair_count = r_pair_count;

    // Checks
    `CBH_ASSERT_IMP(a_clr_blocks_in, i_clk, i_rst_n, r_clr_busy, o_in_stall && !r_s_valid,
        "request taken during clearing pass")
    `CBH_ASSERT_IMP(a_clr_no_update, i_clk, i_rst_n, r_clr_busy, !w_op_we,
        "counter update during clearing pass")
    `CBH_ASSERT_NXT(a_read_gives_result, i_clk, i_rst_n, w_retire && r_s_cmd, r_out_valid,
        "read request retired without a result")
    `CBH_ASSERT_IMP(a_held_result_blocks_read, i_clk, i_rst_n,
        r_out_valid && i_out_stall && r_s_valid && r_s_cmd, !w_retire,
        "read retired over a held result")

endmodule

@@ bench/char_bigram_histogram_tb.sv @@
`timescale 1ns / 100ps
// Testbench for char_bigram_histogram: directed, long-run and random text requests
// checked against an in-bench pair counter model. Depends on cbh_pkg and the RTL.
module char_bigram_histogram_tb;
    import cbh_pkg::*;

    // Counter width as built for the reference behavior
    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] TALLY_MAX = '1;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHAR_BQUOTE  = 8'h60;
    localparam logic [7:0] CHAR_LBRACE  = 8'h7B;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_cmd          = CMD_BYTE;
    logic [7:0]  i_byte_value   = '0;
    logic [4:0]  i_first_class  = '0;
    logic [4:0]  i_second_class = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [31:0] o_pair_count;

    // Bench-side copy of the histogram state
    logic [CNT_W-1:0] pair_tally [PAIR_DEPTH] = '{default: '0};
    t_class           prev_class   = CLASS_NONE;
    t_class           recent_lead  = '0;
    t_class           recent_trail = '0;
    logic [31:0]      expected_counts [$];

    bit          idle_en    = 1'b1;
    int          mismatches = 0;
    int          sent_count = 0;
    logic [31:0] want_count;

    char_bigram_histogram #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_byte_value  (i_byte_value),
        .i_first_class (i_first_class),
        .i_second_class(i_second_class),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pair_count  (o_pair_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the pipe hangs
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Byte to class: letters fold to 0..25, space, newline, else none
    function automatic t_class class_of(input logic [7:0] b);
        if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) return t_class'(b - CHAR_LOWER_A);
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return t_class'(b - CHAR_UPPER_A);
        if (b == CHAR_SPACE) return CLASS_SPACE;
        if (b == CHAR_NEWLINE) return CLASS_NEWLINE;
        return CLASS_NONE;
    endfunction

    // Apply one accepted request to the bench histogram
    function automatic void tally_request(input logic cmd, input logic [7:0] b,
                                          input t_class lead, input t_class trail);
        t_class      c;
        int          idx;
        logic [63:0] v;
        if (cmd == CMD_READ) begin
            v = '0;
            if (lead < NUM_CLASSES && trail < NUM_CLASSES) begin
                v = 64'(pair_tally[int'(lead) * NUM_CLASSES + int'(trail)]);
            end
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            expected_counts.push_back(v[31:0]);
        end else begin
            c = class_of(b);
            if (c < NUM_CLASSES && prev_class < NUM_CLASSES) begin
                idx = int'(prev_class) * NUM_CLASSES + int'(c);
                if (pair_tally[idx] != TALLY_MAX) pair_tally[idx] += 1'b1;
                recent_lead  = prev_class;
                recent_trail = c;
            end
            // a newline ends the line: the next byte has no predecessor
            prev_class = (c == CLASS_NEWLINE) ? CLASS_NONE : c;
        end
    endfunction

    // Present one request, hold it through stalls, predict on acceptance
    task automatic send_request(input logic cmd, input logic [7:0] b,
                                input logic [4:0] lead, input logic [4:0] trail);
        // idle cycles drawn one at a time
        while (idle_en && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_byte_value   <= b;
        i_first_class  <= lead;
        i_second_class <= trail;
        do @(posedge i_clk); while (o_in_stall);
        tally_request(cmd, b, lead, trail);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(CMD_BYTE, b, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    endtask

    task automatic send_read(input logic [4:0] lead, input logic [4:0] trail);
        send_request(CMD_READ, 8'($urandom_range(0, 255)), lead, trail);
    endtask

    // Hold off new requests until every pending count has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_counts.size() != 0);
    endtask

    // Result side: random stall, compare each accepted count in order
    always @(posedge i_clk) begin
        i_out_stall <= idle_en && ($urandom_range(0, 99) < 19);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("unexpected result", o_pair_count, '0);
            end else begin
                want_count = expected_counts.pop_front();
                if (o_pair_count !== want_count) begin
                    report_mismatch("pair_count", o_pair_count, want_count);
                end
            end
        end
    end

    // Class boundaries, unclassed bytes, newline handling, read corner cases
    task automatic test_directed_classes();
        idle_en = 1'b0;
        send_byte(CHAR_LOWER_A);
        send_byte(CHAR_UPPER_Z);
        send_byte(CHAR_LOWER_Z);
        send_byte(CHAR_UPPER_A);
        send_byte(CHAR_SPACE);
        send_byte(CHAR_NEWLINE);
        send_byte(8'h6D);
        send_byte(CHAR_AT);
        send_byte(8'h62);
        send_byte(CHAR_LBRACK);
        send_byte(CHAR_BQUOTE);
        send_byte(CHAR_LBRACE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'hE1);
        send_byte(8'h71);
        // a read between two bytes must not break the pair
        send_read(5'd0, 5'd25);
        send_byte(8'h72);
        send_read(5'd16, 5'd17);
        send_read(CLASS_NONE, 5'd0);
        send_read(5'd0, CLASS_NONE);
        send_read(5'd28, CLASS_LAST);
        send_read(CLASS_NEWLINE, CLASS_NEWLINE);
        send_read(5'd0, CLASS_SPACE);
        idle_en = 1'b1;
    endtask

    // Long run of one letter hammers a single counter, reads sampled mid-run
    task automatic test_long_letter_run();
        send_byte(CHAR_NEWLINE);
        for (int i = 0; i < 300; i++) begin
            send_byte(($urandom_range(0, 1) != 0) ? CHAR_UPPER_A : CHAR_LOWER_A);
            if (i == 100 || i == 254 || i == 256) send_read(5'd0, 5'd0);
        end
        send_byte(CHAR_NEWLINE);
        send_read(5'd0, 5'd0);
        send_read(5'd0, CLASS_NEWLINE);
    endtask

    // Words of mixed case with spaces and newlines, some noise, reads mixed in
    task automatic test_random_text(input int n_items);
        int         stop_at;
        int         mid;
        int         pick;
        int         len;
        bit         drained;
        logic [7:0] ch;
        stop_at = sent_count + n_items;
        mid     = sent_count + n_items / 2;
        drained = 1'b0;
        while (sent_count < stop_at) begin
            // quiet stretch with no idling on either side
            idle_en = !(sent_count >= mid - n_items / 4 && sent_count < mid);
            if (!drained && sent_count >= mid) begin
                wait_for_results();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    ch = (($urandom_range(0, 1) != 0) ? CHAR_UPPER_A : CHAR_LOWER_A)
                         + 8'($urandom_range(0, 25));
                    send_byte(ch);
                end
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    send_byte(CHAR_SPACE);
                end else if (pick < 92) begin
                    send_byte(CHAR_NEWLINE);
                end else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end else if (pick < 82) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    send_read(recent_lead, recent_trail);
                end else if (pick < 90) begin
                    send_read(5'($urandom_range(0, 27)), 5'($urandom_range(0, 27)));
                end else begin
                    send_read(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
                end
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_classes();
        wait_for_results();
        test_long_letter_run();
        wait_for_results();
        test_random_text(870);
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
